@@ rtl/mcs_pkg.sv @@
package mcs_pkg;

  localparam int unsigned AccW  = 32;
  localparam int unsigned LineW = 10;
  localparam int unsigned StepW = 6;
  localparam int unsigned AddrW = 4;

  localparam logic [AccW-1:0] UnitOne       = 32'h0100_0000;
  localparam logic [AccW-1:0] FracMask      = 32'h00FF_FFFF;
  localparam logic [AccW-1:0] SoundRate     = 32'd44100;
  localparam logic [AccW-1:0] TimerBaseHalf = 32'd12500000;
  localparam logic [AccW-1:0] TimerBaseFull = 32'd25000000;
  localparam logic [AccW-1:0] CpuClockRst   = 32'd12500000;
  localparam logic [LineW-1:0] FrameLinesRst = 10'd526;

  localparam logic [StepW-1:0] StepsUnits = 6'd32;
  localparam logic [StepW-1:0] StepsRate  = 6'd32;
  localparam logic [StepW-1:0] StepsWrap  = 6'd11;
  localparam logic [StepW-1:0] StepsHalf  = 6'd10;

  typedef enum logic [1:0] {
    OP_PUSH,
    OP_TAKE_VIDEO,
    OP_TAKE_SOUND,
    OP_TAKE_TIMER
  } op_e;

  typedef enum logic [1:0] {
    REG_CPU_CLOCK,
    REG_FRAME_LINES,
    REG_TIMER_DELAY,
    REG_TIMER_HALF_BASE
  } reg_idx_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DIV_UNITS,
    S_MUL_CPU,
    S_FIX,
    S_MUL_SOUND,
    S_MUL_VIDEO,
    S_ADD_VIDEO,
    S_DIV_RATE,
    S_MUL_TIMER,
    S_ADD_TIMER,
    S_TAKE,
    S_DIV_WRAP,
    S_LINE,
    S_DIV_HALF,
    S_DONE
  } state_e;

  typedef struct packed {
    op_e        operation;
    logic [7:0] cycle_count;
  } in_item_t;

  typedef struct packed {
    logic             event_taken;
    logic [LineW-1:0] line_in_field;
    logic [1:0]       half_frame;
    logic [LineW-1:0] frame_line;
  } out_item_t;

  typedef struct packed {
    logic [AccW-1:0]  cpu_clock;
    logic [LineW-1:0] frame_lines;
    logic [15:0]      timer_delay;
    logic             timer_half_base;
  } cfg_t;

  typedef struct packed {
    logic frame_lines;
    logic timer;
  } cfg_wr_t;

  typedef struct packed {
    logic             start;
    logic [AccW-1:0]  dividend;
    logic [AccW-1:0]  divisor;
    logic [StepW-1:0] steps;
  } div_req_t;

  typedef struct packed {
    logic            busy;
    logic            done;
    logic [AccW-1:0] quotient;
    logic [AccW-1:0] remainder;
  } div_rsp_t;

endpackage

@@ rtl/mcs_div.sv @@
module mcs_div (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  mcs_pkg::div_req_t req_i,
  output mcs_pkg::div_rsp_t rsp_o
);
  import mcs_pkg::*;

  logic [AccW-1:0]  quo_q, quo_d;
  logic [AccW-1:0]  rem_q, rem_d;
  logic [AccW-1:0]  dsr_q, dsr_d;
  logic [StepW-1:0] cnt_q, cnt_d;
  logic             busy_q, busy_d;
  logic             done_q, done_d;
  logic [AccW:0]    rem_sh;
  logic [AccW:0]    diff;

  always_comb begin
    rem_sh = {rem_q, quo_q[AccW-1]};
    diff   = rem_sh - {1'b0, dsr_q};
    quo_d  = quo_q;
    rem_d  = rem_q;
    dsr_d  = dsr_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (req_i.start) begin
      quo_d  = req_i.dividend;
      rem_d  = '0;
      dsr_d  = req_i.divisor;
      cnt_d  = req_i.steps;
      busy_d = 1'b1;
    end else if (busy_q) begin
      if (!diff[AccW]) begin
        rem_d = diff[AccW-1:0];
        quo_d = {quo_q[AccW-2:0], 1'b1};
      end else begin
        rem_d = rem_sh[AccW-1:0];
        quo_d = {quo_q[AccW-2:0], 1'b0};
      end
      cnt_d = cnt_q - StepW'(1);
      if (cnt_q == StepW'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    dsr_q <= dsr_d;
  end

  assign rsp_o.busy      = busy_q;
  assign rsp_o.done      = done_q;
  assign rsp_o.quotient  = quo_q;
  assign rsp_o.remainder = rem_q;

  a_no_restart : assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_i.start |-> !busy_q)
    else $error("Divider started while a division is still running.");

endmodule

@@ rtl/mcs_cfg.sv @@
module mcs_cfg (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      psel,
  input  logic                      penable,
  input  logic                      pwrite,
  input  logic [mcs_pkg::AddrW-1:0] paddr,
  input  logic [31:0]               pwdata,
  output logic [31:0]               prdata,
  output logic                      pready,
  output mcs_pkg::cfg_t             cfg_o,
  output mcs_pkg::cfg_wr_t          wr_o
);
  import mcs_pkg::*;

  cfg_t     cfg_q, cfg_d;
  cfg_wr_t  wr_d;
  reg_idx_e idx;
  logic     wen;

  assign idx    = reg_idx_e'(paddr[AddrW-1:2]);
  assign wen    = psel && penable && pwrite;
  assign pready = 1'b1;

  always_comb begin
    cfg_d = cfg_q;
    wr_d  = '0;
    if (wen) begin
      unique case (idx)
        REG_CPU_CLOCK:       cfg_d.cpu_clock = pwdata;
        REG_FRAME_LINES: begin
          cfg_d.frame_lines = pwdata[LineW-1:0];
          wr_d.frame_lines  = 1'b1;
        end
        REG_TIMER_DELAY: begin
          cfg_d.timer_delay = pwdata[15:0];
          wr_d.timer        = 1'b1;
        end
        REG_TIMER_HALF_BASE: begin
          cfg_d.timer_half_base = pwdata[0];
          wr_d.timer            = 1'b1;
        end
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_CPU_CLOCK:       prdata = cfg_q.cpu_clock;
      REG_FRAME_LINES:     prdata = {22'd0, cfg_q.frame_lines};
      REG_TIMER_DELAY:     prdata = {16'd0, cfg_q.timer_delay};
      REG_TIMER_HALF_BASE: prdata = {31'd0, cfg_q.timer_half_base};
      default:             prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.cpu_clock       <= CpuClockRst;
      cfg_q.frame_lines     <= FrameLinesRst;
      cfg_q.timer_delay     <= '0;
      cfg_q.timer_half_base <= 1'b0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;
  assign wr_o  = wr_d;

endmodule

@@ rtl/multi_rate_clock_event_scheduler.sv @@
// Channel  | Direction | Handshake                | Payload
// input    | in        | in_valid_i / in_stall_o  | in_item_i   (operation, cycle_count)
// output   | out       | out_valid_o / out_stall_i| out_item_o  (event_taken, line fields)
// config   | in        | psel, penable, pwrite    | paddr, pwdata / prdata
//
// A push goes through the shared radix-2 divider for the unit count, and through the timer
// steps as well when the timer is enabled.
// After a timer register write the first timer push also runs the timer rate division.
// A take that advances the line counter sends the line wrap and the field split each through
// the divider, or only the field split when frame_lines is zero.
// After a frame_lines write the next item runs the field split.
// Reset clears all accumulators and the line counter; the block takes one item at a time.
// A finished result waits in the output register while the next item is accepted.
module multi_rate_clock_event_scheduler (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  output logic                      in_stall_o,
  input  mcs_pkg::in_item_t         in_item_i,
  output logic                      out_valid_o,
  input  logic                      out_stall_i,
  output mcs_pkg::out_item_t        out_item_o,
  input  logic                      psel,
  input  logic                      penable,
  input  logic                      pwrite,
  input  logic [mcs_pkg::AddrW-1:0] paddr,
  input  logic [31:0]               pwdata,
  output logic [31:0]               prdata,
  output logic                      pready
);
  import mcs_pkg::*;

  cfg_t      cfg;
  cfg_wr_t   cfg_wr;
  div_req_t  div_req;
  div_rsp_t  div_rsp;
  state_e    state_q, state_d;
  in_item_t  item_q, item_d;
  out_item_t out_item_q, out_item_d;
  logic      out_valid_q, out_valid_d;
  logic      taken_q, taken_d;
  logic      line_dirty_q, line_dirty_d;
  logic      rate_dirty_q, rate_dirty_d;

  logic [AccW-1:0]  units_q, units_d;
  logic [AccW-1:0]  prod_q, prod_d;
  logic [AccW-1:0]  rate_q, rate_d;
  logic [AccW-1:0]  cpu_acc_q, cpu_acc_d;
  logic [AccW-1:0]  snd_acc_q, snd_acc_d;
  logic [AccW-1:0]  vid_acc_q, vid_acc_d;
  logic [AccW-1:0]  tmr_acc_q, tmr_acc_d;
  logic [LineW-1:0] line_q, line_d;
  logic [LineW-1:0] lif_q, lif_d;
  logic [1:0]       half_q, half_d;

  logic [AccW-1:0]  mul_b;
  logic [AccW-1:0]  cpu_sum;
  logic [AccW-1:0]  vid_rate;
  logic [AccW-1:0]  timer_base;
  logic [LineW-1:0] half_lines;
  logic [LineW:0]   line_next;

  mcs_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg),
    .wr_o    (cfg_wr)
  );

  mcs_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  assign vid_rate   = {17'd0, ({cfg.frame_lines, 5'd0} - {4'd0, cfg.frame_lines, 1'b0})};
  assign timer_base = cfg.timer_half_base ? TimerBaseHalf : TimerBaseFull;
  assign half_lines = (cfg.frame_lines[LineW-1:1] == '0) ? LineW'(1)
                                                         : {1'b0, cfg.frame_lines[LineW-1:1]};
  assign line_next  = {1'b0, line_q} + (LineW+1)'(1);
  assign cpu_sum    = cpu_acc_q + prod_q;
  assign prod_d     = units_q * mul_b;

  always_comb begin
    state_d      = state_q;
    item_d       = item_q;
    out_item_d   = out_item_q;
    out_valid_d  = out_valid_q;
    taken_d      = taken_q;
    line_dirty_d = line_dirty_q;
    rate_dirty_d = rate_dirty_q;
    units_d      = units_q;
    rate_d       = rate_q;
    cpu_acc_d    = cpu_acc_q;
    snd_acc_d    = snd_acc_q;
    vid_acc_d    = vid_acc_q;
    tmr_acc_d    = tmr_acc_q;
    line_d       = line_q;
    lif_d        = lif_q;
    half_d       = half_q;
    mul_b        = cfg.cpu_clock;
    div_req      = '0;

    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          item_d  = in_item_i;
          taken_d = 1'b0;
          if (in_item_i.operation == OP_PUSH) begin
            div_req.start    = 1'b1;
            div_req.dividend = {in_item_i.cycle_count, 24'd0};
            div_req.divisor  = cfg.cpu_clock;
            div_req.steps    = StepsUnits;
            state_d          = S_DIV_UNITS;
          end else begin
            state_d = S_TAKE;
          end
        end
      end
      S_DIV_UNITS: begin
        if (div_rsp.done) begin
          units_d = div_rsp.quotient;
          state_d = S_MUL_CPU;
        end
      end
      S_MUL_CPU: begin
        mul_b   = cfg.cpu_clock;
        state_d = S_FIX;
      end
      S_FIX: begin
        if (cpu_sum[AccW-1:24] != item_q.cycle_count) begin
          units_d   = units_q + AccW'(1);
          cpu_acc_d = (cpu_sum + cfg.cpu_clock) & FracMask;
        end else begin
          cpu_acc_d = cpu_sum;
        end
        state_d = S_MUL_SOUND;
      end
      S_MUL_SOUND: begin
        mul_b   = SoundRate;
        state_d = S_MUL_VIDEO;
      end
      S_MUL_VIDEO: begin
        snd_acc_d = snd_acc_q + prod_q;
        mul_b     = vid_rate;
        state_d   = S_ADD_VIDEO;
      end
      S_ADD_VIDEO: begin
        vid_acc_d = vid_acc_q + prod_q;
        if (cfg.timer_delay == '0) begin
          state_d = S_LINE;
        end else if (rate_dirty_q) begin
          div_req.start    = 1'b1;
          div_req.dividend = timer_base;
          div_req.divisor  = {16'd0, cfg.timer_delay};
          div_req.steps    = StepsRate;
          state_d          = S_DIV_RATE;
        end else begin
          state_d = S_MUL_TIMER;
        end
      end
      S_DIV_RATE: begin
        if (div_rsp.done) begin
          rate_d       = div_rsp.quotient;
          rate_dirty_d = 1'b0;
          state_d      = S_MUL_TIMER;
        end
      end
      S_MUL_TIMER: begin
        mul_b   = rate_q;
        state_d = S_ADD_TIMER;
      end
      S_ADD_TIMER: begin
        tmr_acc_d = tmr_acc_q + prod_q;
        state_d   = S_LINE;
      end
      S_TAKE: begin
        state_d = S_LINE;
        unique case (item_q.operation)
          OP_TAKE_VIDEO: begin
            if (vid_acc_q[AccW-1:24] != '0) begin
              vid_acc_d = vid_acc_q - UnitOne;
              taken_d   = 1'b1;
              if (cfg.frame_lines == '0) begin
                line_d       = line_next[LineW-1:0];
                line_dirty_d = 1'b1;
              end else begin
                div_req.start    = 1'b1;
                div_req.dividend = {line_next, 21'd0};
                div_req.divisor  = {22'd0, cfg.frame_lines};
                div_req.steps    = StepsWrap;
                state_d          = S_DIV_WRAP;
              end
            end
          end
          OP_TAKE_SOUND: begin
            if (snd_acc_q[AccW-1:24] != '0) begin
              snd_acc_d = snd_acc_q - UnitOne;
              taken_d   = 1'b1;
            end
          end
          OP_TAKE_TIMER: begin
            if (tmr_acc_q[AccW-1:24] != '0) begin
              tmr_acc_d = tmr_acc_q - UnitOne;
              taken_d   = 1'b1;
            end
          end
          default: ;
        endcase
      end
      S_DIV_WRAP: begin
        if (div_rsp.done) begin
          line_d       = div_rsp.remainder[LineW-1:0];
          line_dirty_d = 1'b1;
          state_d      = S_LINE;
        end
      end
      S_LINE: begin
        if (line_dirty_q) begin
          div_req.start    = 1'b1;
          div_req.dividend = {line_q, 22'd0};
          div_req.divisor  = {22'd0, half_lines};
          div_req.steps    = StepsHalf;
          state_d          = S_DIV_HALF;
        end else begin
          state_d = S_DONE;
        end
      end
      S_DIV_HALF: begin
        if (div_rsp.done) begin
          lif_d        = div_rsp.remainder[LineW-1:0];
          half_d       = div_rsp.quotient[1:0];
          line_dirty_d = 1'b0;
          state_d      = S_DONE;
        end
      end
      S_DONE: begin
        if (!out_valid_q || !out_stall_i) begin
          out_item_d.event_taken   = taken_q;
          out_item_d.line_in_field = lif_q;
          out_item_d.half_frame    = half_q;
          out_item_d.frame_line    = line_q;
          out_valid_d              = 1'b1;
          state_d                  = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase

    if (cfg_wr.frame_lines) begin
      line_dirty_d = 1'b1;
    end
    if (cfg_wr.timer) begin
      rate_dirty_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      out_valid_q  <= 1'b0;
      line_dirty_q <= 1'b0;
      rate_dirty_q <= 1'b1;
      cpu_acc_q    <= '0;
      snd_acc_q    <= '0;
      vid_acc_q    <= '0;
      tmr_acc_q    <= '0;
      line_q       <= '0;
      lif_q        <= '0;
      half_q       <= '0;
    end else begin
      state_q      <= state_d;
      out_valid_q  <= out_valid_d;
      line_dirty_q <= line_dirty_d;
      rate_dirty_q <= rate_dirty_d;
      cpu_acc_q    <= cpu_acc_d;
      snd_acc_q    <= snd_acc_d;
      vid_acc_q    <= vid_acc_d;
      tmr_acc_q    <= tmr_acc_d;
      line_q       <= line_d;
      lif_q        <= lif_d;
      half_q       <= half_d;
    end
  end

  always_ff @(posedge clk_i) begin
    item_q     <= item_d;
    out_item_q <= out_item_d;
    taken_q    <= taken_d;
    units_q    <= units_d;
    prod_q     <= prod_d;
    rate_q     <= rate_d;
  end

  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

  a_done_loads : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DONE) && !out_valid_q |=> out_valid_q)
    else $error("A finished item was not loaded into a free output register.");

  a_field_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !line_dirty_q |-> (lif_q < half_lines))
    else $error("Line within field is not below half the frame lines.");

  a_idle_div : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_IDLE) |-> !div_rsp.busy)
    else $error("Divider still busy while the sequencer is idle.");

endmodule
